[hdl/qphs_pkg.sv]
package qphs_pkg;

   // table geometry
   localparam int DEF_TABLE_SLOTS = 127;
   localparam int KEY_W = 32;
   localparam int KIND_W = 2;
   localparam int COUNT_W = 6;
   localparam int COUNT_MAX = 63;
   localparam int SLOT_OUT_W = 7;

   // response packing: success, status, slot, occupied, table_empty
   localparam int RSP_FIELDS_W = 1 + 2 + SLOT_OUT_W + COUNT_W + 1;
   localparam int RSP_W = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W = RSP_W - RSP_FIELDS_W;

   // operation codes
   typedef enum logic [KIND_W-1:0] {
      KIND_LOOKUP = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   // slot tag codes
   typedef enum logic [1:0] {
      TAG_EMPTY   = 2'd0,
      TAG_ACTIVE  = 2'd1,
      TAG_DELETED = 2'd2
   } tag_type;

   // one table entry
   typedef struct packed {
      tag_type          tag;
      logic [KEY_W-1:0] key;
   } entry_type;

endpackage

[hdl/quadratic_probing_hash_set_core.sv]
// quadratic probing hash set of 32-bit keys, identity hash, prime sized table
//
// req channel: tuser carries the operation (lookup, insert, remove, clear),
// tdata the key. rsp channel: one item per request with success, status,
// final probe slot, occupied count and an empty flag.
//
// an item first finds the home slot (a multiply by the reciprocal of the table
// size, then one correcting subtract), then probes one slot at a time, a read
// state and then a check state per slot, through the single read port of the
// slot memory, then writes back and loads the response. p, the number of
// probes, is small while the table is at most half full and bounded by
// TABLE_SLOTS. a clear sweeps the memory, one slot a cycle, and then answers.
// one item is worked on at a time.
//
// after reset the same sweep runs over every slot with req_tready low.
// the response sits in an output register: the next request is taken while
// it waits, and a new response is only loaded once the old one has gone,
// so a stalled receiver holds the block at its write-back step.
module quadratic_probing_hash_set_core #(
   parameter int TABLE_SLOTS = qphs_pkg::DEF_TABLE_SLOTS
) (
   input  logic                        clock,
   input  logic                        reset,
   // request
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [qphs_pkg::KEY_W-1:0]  req_tdata,  // [31:0] key
   input  logic [qphs_pkg::KIND_W-1:0] req_tuser,  // [1:0] kind
   // response
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [0] success, [2:1] status, [9:3] slot, [15:10] occupied,
   // [16] table_empty, [23:17] zero
   output logic [qphs_pkg::RSP_W-1:0]  rsp_tdata
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);
   localparam logic [IDX_W:0] SLOTS_EXT = (IDX_W + 1)'(TABLE_SLOTS);
   localparam int HALF_SLOTS = TABLE_SLOTS / 2;
   localparam int CAP_INT = (HALF_SLOTS < qphs_pkg::COUNT_MAX) ? HALF_SLOTS
                                                               : qphs_pkg::COUNT_MAX;
   localparam logic [qphs_pkg::COUNT_W-1:0] COUNT_CAP = qphs_pkg::COUNT_W'(CAP_INT);
   // floor(2^32 / TABLE_SLOTS): the quotient estimate is at most one short
   localparam logic [qphs_pkg::KEY_W-1:0] RECIP =
      qphs_pkg::KEY_W'((64'd1 << qphs_pkg::KEY_W) / TABLE_SLOTS);

   typedef enum logic [7:0] {
      S_INIT  = 8'b00000001,
      S_IDLE  = 8'b00000010,
      S_MUL   = 8'b00000100,
      S_MOD   = 8'b00001000,
      S_READ  = 8'b00010000,
      S_CHECK = 8'b00100000,
      S_CLEAR = 8'b01000000,
      S_REPLY = 8'b10000000
   } state_type;

   state_type                        state_ff, state_in;
   qphs_pkg::kind_type               kind_ff, kind_in;
   logic [qphs_pkg::KEY_W-1:0]       key_ff, key_in;
   logic [qphs_pkg::KEY_W-1:0]       quot_ff, quot_in;
   logic [IDX_W-1:0]                 pos_ff, pos_in;
   logic [IDX_W-1:0]                 step_ff, step_in;
   logic [IDX_W-1:0]                 probe_cnt_ff, probe_cnt_in;
   logic                             ended_ff, ended_in;
   logic                             active_ff, active_in;
   logic [qphs_pkg::COUNT_W-1:0]     used_cnt_ff, used_cnt_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_success_ff, rsp_success_in;
   qphs_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [qphs_pkg::SLOT_OUT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [qphs_pkg::COUNT_W-1:0]     rsp_occ_ff, rsp_occ_in;

   qphs_pkg::entry_type              slot_mem_ff [TABLE_SLOTS];
   qphs_pkg::entry_type              rd_ff;
   logic                             mem_we;
   qphs_pkg::entry_type              mem_wdata;

   logic                             out_free;
   logic [2*qphs_pkg::KEY_W-1:0]     recip_prod;
   logic [IDX_W:0]                   fold_prod;
   logic [IDX_W:0]                   rem_est;
   logic [IDX_W:0]                   pos_sum;
   logic [IDX_W:0]                   step_sum;
   logic [IDX_W:0]                   probe_next;
   logic                             probe_stop;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // shared arithmetic: reciprocal multiply, remainder fold, probe advance
   assign recip_prod = {{qphs_pkg::KEY_W{1'b0}}, key_ff} * {{qphs_pkg::KEY_W{1'b0}}, RECIP};
   assign fold_prod  = quot_ff[IDX_W:0] * SLOTS_EXT;
   assign rem_est    = key_ff[IDX_W:0] - fold_prod;
   assign pos_sum    = {1'b0, pos_ff} + {1'b0, step_ff};
   assign step_sum   = {1'b0, step_ff} + (IDX_W + 1)'(2);
   assign probe_next = {1'b0, probe_cnt_ff} + (IDX_W + 1)'(1);
   assign probe_stop = (rd_ff.tag == qphs_pkg::TAG_EMPTY) || (rd_ff.key == key_ff);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      key_in         = key_ff;
      quot_in        = quot_ff;
      pos_in         = pos_ff;
      step_in        = step_ff;
      probe_cnt_in   = probe_cnt_ff;
      ended_in       = ended_ff;
      active_in      = active_ff;
      used_cnt_in    = used_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_success_in = rsp_success_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_occ_in     = rsp_occ_ff;
      mem_we         = 1'b0;
      mem_wdata      = '{tag: qphs_pkg::TAG_EMPTY, key: key_ff};
      unique case (state_ff)
         S_INIT, S_CLEAR: begin
            // sweep every slot to empty
            mem_we = 1'b1;
            if (pos_ff == LAST_SLOT) begin
               pos_in   = '0;
               state_in = (state_ff == S_INIT) ? S_IDLE : S_REPLY;
            end else begin
               pos_in = pos_ff + IDX_W'(1);
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in = qphs_pkg::kind_type'(req_tuser);
               key_in  = req_tdata;
               pos_in  = '0;
               state_in = (qphs_pkg::kind_type'(req_tuser) == qphs_pkg::KIND_CLEAR)
                          ? S_CLEAR : S_MUL;
            end
         end
         S_MUL: begin
            // quotient estimate from the reciprocal
            quot_in  = recip_prod[2*qphs_pkg::KEY_W-1:qphs_pkg::KEY_W];
            state_in = S_MOD;
         end
         S_MOD: begin
            // remainder estimate is below twice the table size
            pos_in       = (rem_est >= SLOTS_EXT) ? IDX_W'(rem_est - SLOTS_EXT)
                                                  : IDX_W'(rem_est);
            step_in      = IDX_W'(1);
            probe_cnt_in = '0;
            state_in     = S_READ;
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (probe_stop) begin
               ended_in  = 1'b1;
               active_in = (rd_ff.tag == qphs_pkg::TAG_ACTIVE);
               state_in  = S_REPLY;
            end else if (probe_next < SLOTS_EXT) begin
               pos_in       = (pos_sum >= SLOTS_EXT) ? IDX_W'(pos_sum - SLOTS_EXT)
                                                     : IDX_W'(pos_sum);
               step_in      = (step_sum >= SLOTS_EXT) ? IDX_W'(step_sum - SLOTS_EXT)
                                                      : IDX_W'(step_sum);
               probe_cnt_in = IDX_W'(probe_next);
               state_in     = S_READ;
            end else begin
               ended_in  = 1'b0;
               active_in = 1'b0;
               state_in  = S_REPLY;
            end
         end
         S_REPLY: begin
            // write back and load the response once the output is free
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_success_in = 1'b0;
               rsp_status_in  = qphs_pkg::STATUS_OK;
               rsp_slot_in    = qphs_pkg::SLOT_OUT_W'(pos_ff);
               unique case (kind_ff)
                  qphs_pkg::KIND_LOOKUP: begin
                     rsp_success_in = active_ff;
                     rsp_status_in  = active_ff ? qphs_pkg::STATUS_OK
                                                : qphs_pkg::STATUS_MISS;
                  end
                  qphs_pkg::KIND_REMOVE: begin
                     if (active_ff) begin
                        mem_we         = 1'b1;
                        mem_wdata.tag  = qphs_pkg::TAG_DELETED;
                        rsp_success_in = 1'b1;
                     end else begin
                        rsp_status_in = qphs_pkg::STATUS_MISS;
                     end
                  end
                  qphs_pkg::KIND_INSERT: begin
                     if (active_ff) begin
                        rsp_status_in = qphs_pkg::STATUS_MISS;
                     end else if (!ended_ff || used_cnt_ff >= COUNT_CAP) begin
                        rsp_status_in = qphs_pkg::STATUS_FULL;
                     end else begin
                        mem_we         = 1'b1;
                        mem_wdata.tag  = qphs_pkg::TAG_ACTIVE;
                        used_cnt_in    = used_cnt_ff + qphs_pkg::COUNT_W'(1);
                        rsp_success_in = 1'b1;
                     end
                  end
                  qphs_pkg::KIND_CLEAR: begin
                     used_cnt_in    = '0;
                     rsp_success_in = 1'b1;
                     rsp_slot_in    = '0;
                  end
               endcase
               rsp_occ_in = used_cnt_in;
               state_in   = S_IDLE;
            end
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         pos_ff       <= '0;
         used_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         used_cnt_ff  <= used_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      key_ff         <= key_in;
      quot_ff        <= quot_in;
      step_ff        <= step_in;
      probe_cnt_ff   <= probe_cnt_in;
      ended_ff       <= ended_in;
      active_ff      <= active_in;
      rsp_success_ff <= rsp_success_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   // slot memory, one port at the probe position
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[pos_ff] <= mem_wdata;
      end
      rd_ff <= slot_mem_ff[pos_ff];
   end

   // ports
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{qphs_pkg::RSP_PAD_W{1'b0}}, (rsp_occ_ff == '0), rsp_occ_ff,
                        rsp_slot_ff, rsp_status_ff, rsp_success_ff};

   // checks
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      used_cnt_ff <= COUNT_CAP)
      else $error("occupied count above the table limit");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_SLOT)
      else $error("probe position outside the table");

   a_success_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_success_ff |-> rsp_status_ff == qphs_pkg::STATUS_OK)
      else $error("successful response with a failure status");

   a_empty_stops: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHECK && rd_ff.tag == qphs_pkg::TAG_EMPTY |=> state_ff == S_REPLY)
      else $error("probe ran past an empty slot");

   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == qphs_pkg::KIND_CLEAR
      |=> state_ff == S_CLEAR && pos_ff == '0)
      else $error("clear did not start its sweep at slot zero");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned SLOTS = qphs_pkg::DEF_TABLE_SLOTS;
   localparam int unsigned CYCLE_LIMIT = 3_000_000;
   localparam int TAIL_CYCLES = 400;
   localparam int RANDOM_ITEMS = 1600;
   // multiplier bound that keeps home + SLOTS * m inside 32 bits
   localparam int unsigned MULT_MAX = 33_000_000;

   // response fields, highest bits first
   typedef struct packed {
      logic [qphs_pkg::RSP_PAD_W-1:0]  pad;
      logic                            table_empty;
      logic [qphs_pkg::COUNT_W-1:0]    occupied;
      logic [qphs_pkg::SLOT_OUT_W-1:0] slot;
      qphs_pkg::status_type            status;
      logic                            success;
   } rsp_item_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [qphs_pkg::KEY_W-1:0]    req_tdata;
   logic [qphs_pkg::KIND_W-1:0]   req_tuser;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [qphs_pkg::RSP_W-1:0]    rsp_tdata;

   // shadow copy of the hash set
   qphs_pkg::tag_type             shadow_tag [SLOTS];
   logic [qphs_pkg::KEY_W-1:0]    shadow_key [SLOTS];
   int unsigned                   shadow_count;

   rsp_item_type       pending_rsp [$];
   int                 mismatches = 0;
   int                 sent_items = 0;
   int                 hold_cycles = 0;
   bit                 calm = 1'b0;
   int unsigned        cycle_count = 0;

   quadratic_probing_hash_set_core #(
      .TABLE_SLOTS(SLOTS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // apply one operation to the shadow set and work out its response
   function automatic rsp_item_type apply_set_op(qphs_pkg::kind_type kind,
                                                 logic [qphs_pkg::KEY_W-1:0] key);
      rsp_item_type r;
      int unsigned  pos;
      int unsigned  stride;
      int unsigned  n;
      bit           ended;
      bit           active;
      r = '0;
      pos = 0;
      ended = 1'b0;
      if (kind == qphs_pkg::KIND_CLEAR) begin
         foreach (shadow_tag[i]) shadow_tag[i] = qphs_pkg::TAG_EMPTY;
         shadow_count = 0;
         r.success = 1'b1;
         r.status = qphs_pkg::STATUS_OK;
      end else begin
         // probe home, home+1, home+4, home+9 ... until empty or same key
         pos = key % SLOTS;
         stride = 1;
         n = 0;
         while (!ended && n < SLOTS) begin
            if (shadow_tag[pos] == qphs_pkg::TAG_EMPTY || shadow_key[pos] == key) begin
               ended = 1'b1;
            end else begin
               if (n + 1 < SLOTS) begin
                  pos = (pos + stride) % SLOTS;
                  stride += 2;
               end
               n++;
            end
         end
         active = ended && shadow_tag[pos] == qphs_pkg::TAG_ACTIVE;
         case (kind)
            qphs_pkg::KIND_LOOKUP: begin
               r.success = active;
               r.status = active ? qphs_pkg::STATUS_OK : qphs_pkg::STATUS_MISS;
            end
            qphs_pkg::KIND_REMOVE: begin
               if (active) begin
                  shadow_tag[pos] = qphs_pkg::TAG_DELETED;
                  r.success = 1'b1;
                  r.status = qphs_pkg::STATUS_OK;
               end else begin
                  r.status = qphs_pkg::STATUS_MISS;
               end
            end
            qphs_pkg::KIND_INSERT: begin
               if (active) begin
                  r.status = qphs_pkg::STATUS_MISS;
               end else if (!ended || shadow_count + 1 > SLOTS / 2
                            || shadow_count + 1 > qphs_pkg::COUNT_MAX) begin
                  r.status = qphs_pkg::STATUS_FULL;
               end else begin
                  // tombstones stay counted, so a revived slot counts again
                  shadow_key[pos] = key;
                  shadow_tag[pos] = qphs_pkg::TAG_ACTIVE;
                  shadow_count++;
                  r.success = 1'b1;
                  r.status = qphs_pkg::STATUS_OK;
               end
            end
            default: ;
         endcase
      end
      r.slot = pos[qphs_pkg::SLOT_OUT_W-1:0];
      r.occupied = shadow_count[qphs_pkg::COUNT_W-1:0];
      r.table_empty = (shadow_count == 0);
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // response checker
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_rsp.size() == 0) begin
            $error("response %h with no request outstanding", rsp_tdata);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("success", want.success, got.success);
            check_field("status", want.status, got.status);
            check_field("slot", want.slot, got.slot);
            check_field("occupied", want.occupied, got.occupied);
            check_field("table_empty", want.table_empty, got.table_empty);
            check_field("pad", want.pad, got.pad);
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready = 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready = calm || ($urandom_range(0, 99) >= 16);
         end
      end
   end

   // offer one item, predict its response once accepted
   task automatic send_op(input qphs_pkg::kind_type kind,
                          input logic [qphs_pkg::KEY_W-1:0] key);
      while (!calm && $urandom_range(0, 99) < 16) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = kind;
      req_tdata = key;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_rsp.push_back(apply_set_op(kind, key));
      sent_items++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // each operation, key extremes, collisions and tombstones
   task automatic test_basic_ops();
      send_op(qphs_pkg::KIND_CLEAR, '1);
      send_op(qphs_pkg::KIND_LOOKUP, '0);
      send_op(qphs_pkg::KIND_REMOVE, 32'd5);
      send_op(qphs_pkg::KIND_INSERT, '0);
      send_op(qphs_pkg::KIND_INSERT, '0);
      send_op(qphs_pkg::KIND_INSERT, '1);
      send_op(qphs_pkg::KIND_LOOKUP, '1);
      // same home slot as key zero
      send_op(qphs_pkg::KIND_INSERT, SLOTS);
      send_op(qphs_pkg::KIND_INSERT, 2 * SLOTS);
      send_op(qphs_pkg::KIND_INSERT, 3 * SLOTS);
      send_op(qphs_pkg::KIND_LOOKUP, 3 * SLOTS);
      // tombstone in the middle of the chain
      send_op(qphs_pkg::KIND_REMOVE, SLOTS);
      send_op(qphs_pkg::KIND_LOOKUP, SLOTS);
      send_op(qphs_pkg::KIND_LOOKUP, 2 * SLOTS);
      send_op(qphs_pkg::KIND_REMOVE, SLOTS);
      // insert over its own tombstone
      send_op(qphs_pkg::KIND_INSERT, SLOTS);
      send_op(qphs_pkg::KIND_INSERT, 4 * SLOTS);
      send_op(qphs_pkg::KIND_LOOKUP, 32'hFFFF_FFFE);
      send_op(qphs_pkg::KIND_REMOVE, '1);
      send_op(qphs_pkg::KIND_CLEAR, '0);
      send_op(qphs_pkg::KIND_LOOKUP, 2 * SLOTS);
      send_op(qphs_pkg::KIND_INSERT, 32'h8000_0000);
      send_op(qphs_pkg::KIND_CLEAR, 32'h5555_5555);
   endtask

   // fill to the count limit behind a stalled receiver, then probe the full table
   task automatic test_table_full();
      int unsigned home;
      int          i;
      home = $urandom_range(0, SLOTS - 1);
      hold_cycles = 800;
      for (i = 0; i < qphs_pkg::COUNT_MAX; i++) begin
         send_op(qphs_pkg::KIND_INSERT, i < 40 ? home + SLOTS * (i + 1) : $urandom());
      end
      wait_drained();
      send_op(qphs_pkg::KIND_INSERT, home);
      send_op(qphs_pkg::KIND_INSERT, home + SLOTS * 40);
      send_op(qphs_pkg::KIND_LOOKUP, home + SLOTS * 40);
      send_op(qphs_pkg::KIND_LOOKUP, home + SLOTS * 1000);
      send_op(qphs_pkg::KIND_REMOVE, home + SLOTS * 20);
      // the tombstone still counts, so this is refused
      send_op(qphs_pkg::KIND_INSERT, home + SLOTS * 20);
      send_op(qphs_pkg::KIND_LOOKUP, home + SLOTS * 20);
      send_op(qphs_pkg::KIND_CLEAR, $urandom());
   endtask

   // sessions over small pools of colliding keys, with some noise
   task automatic test_random_sessions();
      logic [qphs_pkg::KEY_W-1:0] pool [$];
      int unsigned                homes [4];
      logic [qphs_pkg::KEY_W-1:0] key;
      int                         nhomes;
      int                         session;
      int                         first;
      int                         pick;
      session = 0;
      first = sent_items;
      while (sent_items - first < RANDOM_ITEMS) begin
         // one session runs with no idling on either side
         calm = (session == 3);
         nhomes = $urandom_range(1, 4);
         foreach (homes[h]) homes[h] = $urandom_range(0, SLOTS - 1);
         pool.delete();
         repeat ($urandom_range(6, 90)) begin
            pool.push_back(homes[$urandom_range(0, nhomes - 1)]
                           + SLOTS * $urandom_range(0, MULT_MAX));
         end
         repeat ($urandom_range(20, 160)) begin
            pick = $urandom_range(0, 99);
            key = pool[$urandom_range(0, pool.size() - 1)];
            if (pick < 45) begin
               send_op(qphs_pkg::KIND_INSERT, key);
            end else if (pick < 70) begin
               send_op(qphs_pkg::KIND_LOOKUP, key);
            end else if (pick < 88) begin
               send_op(qphs_pkg::KIND_REMOVE, key);
            end else if (pick < 97) begin
               send_op(qphs_pkg::kind_type'($urandom_range(0, 2)), $urandom());
            end else begin
               send_op(qphs_pkg::KIND_CLEAR, $urandom());
            end
         end
         if ($urandom_range(0, 1) == 1) begin
            send_op(qphs_pkg::KIND_CLEAR, $urandom());
         end
         session++;
      end
      calm = 1'b0;
   endtask

   // sequence of tests
   initial begin
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = qphs_pkg::KIND_LOOKUP;
      reset = 1'b1;
      foreach (shadow_key[i]) shadow_key[i] = '0;
      void'(apply_set_op(qphs_pkg::KIND_CLEAR, '0));
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_basic_ops();
      wait_drained();
      test_table_full();
      wait_drained();
      test_random_sessions();
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
